// ===== sv/palette_nearest_color_mapper_top_defines.svh =====
// assertion macros used by the palette mapper controller
`ifndef PALETTE_NEAREST_COLOR_MAPPER_TOP_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_MAPPER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define PNCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pncm check failed: same-cycle implication");

// next-cycle implication, checked on clk, off during rst
`define PNCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pncm check failed: next-cycle implication");

`endif

// ===== sv/pncm_pkg.sv =====
// shared constants, codes and types of the palette mapper
`timescale 1ns / 1ps

package pncm_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int PIX_W       = 32;
  localparam int COLOR_W     = 24;
  localparam int EIDX_W      = 8;
  localparam int PIDX_W      = 9;
  localparam int SQ_W        = 16;
  localparam int DIST_W      = 18;
  localparam int CFG_IW      = 1;
  localparam int CFG_DW      = 32;
  localparam int RW_W        = 2;

  localparam logic [PIDX_W-1:0] NO_MATCH = PIDX_W'(256);

  // opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_MAP    = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_MASK_COLOR = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_RED_WEIGHT = 1'b1;

  typedef logic [CFG_IW-1:0] cfg_idx_t;
  typedef logic [CFG_DW-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              start;
    logic              write;
    logic              rd_en;
    logic [PAL_AW-1:0] rd_addr;
    logic              load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic item_masked;
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/pncm_if.sv =====
// request and response channel interfaces of the palette mapper
`timescale 1ns / 1ps

interface pncm_req_if;
  import pncm_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [EIDX_W-1:0]  entry_index;
  logic [COLOR_W-1:0] entry_color;
  logic [PIX_W-1:0]   pixel;
  logic               last_in;

  modport source (output valid, opcode, entry_index, entry_color, pixel, last_in,
                  input ready);
  modport sink (input valid, opcode, entry_index, entry_color, pixel, last_in,
                output ready);
endinterface

interface pncm_rsp_if;
  import pncm_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  out_pixel;
  logic [PIDX_W-1:0] palette_index;
  logic              masked;
  logic              last_out;

  modport source (output valid, out_pixel, palette_index, masked, last_out,
                  input ready);
  modport sink (input valid, out_pixel, palette_index, masked, last_out,
                output ready);
endinterface

// ===== sv/pncm_ctrl.sv =====
// controller fsm: accepts words, sweeps the palette, hands off results
`timescale 1ns / 1ps
`include "palette_nearest_color_mapper_top_defines.svh"

module pncm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_opcode,
  output logic              in_ready,
  output pncm_pkg::dp_cmd_t cmd,
  input  pncm_pkg::dp_sts_t sts
);
  import pncm_pkg::*;

  localparam logic [PAL_AW-1:0] LAST_ADDR = PAL_AW'(PAL_ENTRIES - 1);

  state_t            state, state_next;
  logic [PAL_AW-1:0] addr, addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

  always_comb begin
    state_next   = state;
    addr_next    = addr;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd_addr  = addr;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        addr_next = '0;
        if (in_valid) begin
          case (in_opcode)
            OP_WRITE: begin
              cmd.write = 1'b1;
            end
            OP_MAP: begin
              cmd.start  = 1'b1;
              state_next = sts.item_masked ? ST_RESULT : ST_SWEEP;
            end
            OP_LOOKUP: begin
              cmd.start  = 1'b1;
              state_next = ST_SWEEP;
            end
            default: begin
              // unused opcode, dropped
            end
          endcase
        end
      end
      ST_SWEEP: begin
        cmd.rd_en = 1'b1;
        addr_next = addr + 1'b1;
        if (addr == LAST_ADDR) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `PNCM_ASSERT_NOW(a_idle_pipe_empty, state == ST_IDLE, !sts.pipe_busy)
  `PNCM_ASSERT_NEXT(a_sweep_ends, (state == ST_SWEEP) && (addr == LAST_ADDR),
                    state == ST_DRAIN)
  `PNCM_ASSERT_NEXT(a_result_holds, (state == ST_RESULT) && !sts.out_free,
                    state == ST_RESULT)

endmodule

// ===== sv/pncm_datapath.sv =====
// datapath: palette memory, distance pipeline, best tracker, output register
`timescale 1ns / 1ps

module pncm_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  pncm_pkg::cfg_idx_t        cfg_index,
  input  pncm_pkg::cfg_data_t       cfg_data,
  input  logic [1:0]                opcode,
  input  logic [pncm_pkg::EIDX_W-1:0]  entry_index,
  input  logic [pncm_pkg::COLOR_W-1:0] entry_color,
  input  logic [pncm_pkg::PIX_W-1:0]   pixel,
  input  logic                      last_in,
  input  pncm_pkg::dp_cmd_t         cmd,
  output pncm_pkg::dp_sts_t         sts,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [pncm_pkg::PIX_W-1:0]  out_pixel,
  output logic [pncm_pkg::PIDX_W-1:0] palette_index,
  output logic                      masked,
  output logic                      last_out
);
  import pncm_pkg::*;

  // configuration
  logic [PIX_W-1:0] mask_color;
  logic [RW_W-1:0]  red_weight;

  // latched item
  logic [PIX_W-1:0]   item_pixel;
  logic               item_last;
  logic               item_lookup;
  logic               item_masked;
  logic [COLOR_W-1:0] want;

  // palette memory
  logic [COLOR_W-1:0] palette_mem [PAL_ENTRIES];
  logic [COLOR_W-1:0] rd_data;

  // pipeline
  logic               s1_valid;
  logic [PAL_AW-1:0]  s1_idx;
  logic               s2_valid;
  logic [PAL_AW-1:0]  s2_idx;
  logic [COLOR_W-1:0] s2_color;
  logic [SQ_W-1:0]    s2_sqr, s2_sqg, s2_sqb;
  logic [7:0]         dr, dg, db;
  logic [DIST_W-1:0]  cand_d;

  // running results
  logic [DIST_W-1:0]  best_d;
  logic [PAL_AW-1:0]  best_idx;
  logic [COLOR_W-1:0] best_color;
  logic [PIDX_W-1:0]  found;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_color <= '0;
      red_weight <= RW_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASK_COLOR: mask_color <= cfg_data[PIX_W-1:0];
        CFG_RED_WEIGHT: red_weight <= cfg_data[RW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_pixel  <= pixel;
      item_last   <= last_in;
      item_lookup <= (opcode == OP_LOOKUP);
      item_masked <= (opcode == OP_MAP) && (pixel == mask_color);
    end
  end

  // pixel bytes reversed into palette order
  assign want = {item_pixel[7:0], item_pixel[15:8], item_pixel[23:16]};

  always_ff @(posedge clk) begin
    if (cmd.write && (PIDX_W'(entry_index) < PIDX_W'(PAL_ENTRIES))) begin
      palette_mem[entry_index[PAL_AW-1:0]] <= entry_color;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= palette_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
    end
  end

  // absolute channel differences
  always_comb begin
    dr = (rd_data[23:16] > item_pixel[7:0]) ? rd_data[23:16] - item_pixel[7:0]
                                            : item_pixel[7:0] - rd_data[23:16];
    dg = (rd_data[15:8] > item_pixel[15:8]) ? rd_data[15:8] - item_pixel[15:8]
                                            : item_pixel[15:8] - rd_data[15:8];
    db = (rd_data[7:0] > item_pixel[23:16]) ? rd_data[7:0] - item_pixel[23:16]
                                            : item_pixel[23:16] - rd_data[7:0];
  end

  always_ff @(posedge clk) begin
    s1_idx   <= cmd.rd_addr;
    s2_idx   <= s1_idx;
    s2_color <= rd_data;
    s2_sqr   <= SQ_W'(dr) * SQ_W'(dr);
    s2_sqg   <= SQ_W'(dg) * SQ_W'(dg);
    s2_sqb   <= SQ_W'(db) * SQ_W'(db);
  end

  // weight 2 when bit 1 of red_weight is set
  assign cand_d = (red_weight[1] ? {1'b0, s2_sqr, 1'b0} : DIST_W'(s2_sqr))
                + DIST_W'(s2_sqg) + DIST_W'(s2_sqb);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found <= NO_MATCH;
    end else if (s2_valid) begin
      if ((s2_idx == '0) || (cand_d < best_d)) begin
        best_d     <= cand_d;
        best_idx   <= s2_idx;
        best_color <= s2_color;
      end
      if ((s2_color == want) && (found == NO_MATCH)) begin
        found <= PIDX_W'(s2_idx);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      last_out <= item_last;
      if (item_lookup) begin
        out_pixel     <= item_pixel;
        palette_index <= found;
        masked        <= 1'b0;
      end else if (item_masked) begin
        out_pixel     <= item_pixel;
        palette_index <= '0;
        masked        <= 1'b1;
      end else begin
        out_pixel     <= {8'h00, best_color[7:0], best_color[15:8], best_color[23:16]};
        palette_index <= PIDX_W'(best_idx);
        masked        <= 1'b0;
      end
    end
  end

  assign sts.item_masked = (pixel == mask_color);
  assign sts.pipe_busy   = s1_valid | s2_valid;
  assign sts.out_free    = !out_valid || out_ready;

endmodule

// ===== sv/palette_nearest_color_mapper_top.sv =====
// top level of the nearest palette color mapper
`timescale 1ns / 1ps

// usage
//   req carries one word per command: opcode 0 writes palette slot entry_index
//   with entry_color, opcode 1 maps pixel to its nearest palette color, opcode 2
//   looks up the first slot equal to pixel's color; opcode 3 is dropped
//   rsp returns one word for opcodes 1 and 2, none for writes
//   cfg_we / cfg_index / cfg_data write mask_color (0) and red_weight (1);
//   write them only while no command is in flight
//   every slot must be written before the first map or lookup
// sequencing and throughput
//   writes are taken at one per cycle while the fsm is idle
//   a masked pixel skips the sweep and goes straight to the result state
//   a map or lookup sweeps all 256 slots through the single memory read port,
//   one slot per cycle, then drains the pipeline and loads the output
//   register; the next word is taken the cycle after the result is loaded
// reset and stalls
//   rst (synchronous) clears the fsm, pipeline and output valid, sets
//   mask_color to 0 and red_weight to 1; palette contents are not cleared
//   the result sits in an output register; while rsp stalls, writes are still
//   taken, and a finished search waits for the register to free up
module palette_nearest_color_mapper_top (
  input  logic                clk,
  input  logic                rst,
  pncm_req_if.sink            req,
  pncm_rsp_if.source          rsp,
  input  logic                cfg_we,
  input  pncm_pkg::cfg_idx_t  cfg_index,
  input  pncm_pkg::cfg_data_t cfg_data
);
  import pncm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign req.ready = in_ready;

  // fsm: sequences the palette sweep and the output load
  pncm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_opcode (req.opcode),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // memory, distance pipeline, best tracking and the output register
  pncm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (req.opcode),
    .entry_index   (req.entry_index),
    .entry_color   (req.entry_color),
    .pixel         (req.pixel),
    .last_in       (req.last_in),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .out_pixel     (rsp.out_pixel),
    .palette_index (rsp.palette_index),
    .masked        (rsp.masked),
    .last_out      (rsp.last_out)
  );

endmodule
